### rtl/wavhp_pkg.sv
`default_nettype none
package wavhp_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        file_start;
		logic [31:0] file_length;
	} in_t;

	typedef struct packed {
		logic [4:0]  error_code;
		logic        is_float;
		logic [15:0] channels;
		logic [31:0] rate_hz;
		logic [5:0]  sample_width;
		logic [31:0] frame_count;
		logic [31:0] audio_start;
		logic [31:0] audio_bytes;
	} out_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD,
		PH_CHDR,
		PH_BODY,
		PH_CONC,
		PH_DIV,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t ph;
		logic   byte_en;
	} cmd_t;

	typedef struct packed {
		logic   fail;
		logic   conclude;
		phase_t next_ph;
		logic   chk_fail;
		logic   div_done;
	} status_t;

	localparam logic [4:0] ERR_OK        = 5'd0;
	localparam logic [4:0] ERR_NO_RIFF   = 5'd1;
	localparam logic [4:0] ERR_SIZE      = 5'd2;
	localparam logic [4:0] ERR_NOT_WAVE  = 5'd3;
	localparam logic [4:0] ERR_CHDR      = 5'd4;
	localparam logic [4:0] ERR_CHUNK     = 5'd5;
	localparam logic [4:0] ERR_FMT_SMALL = 5'd6;
	localparam logic [4:0] ERR_EXT_SMALL = 5'd7;
	localparam logic [4:0] ERR_EXT_SIZE  = 5'd8;
	localparam logic [4:0] ERR_SUBFMT    = 5'd9;
	localparam logic [4:0] ERR_NO_DATA   = 5'd10;
	localparam logic [4:0] ERR_FORMAT    = 5'd11;
	localparam logic [4:0] ERR_VALID     = 5'd12;
	localparam logic [4:0] ERR_FLOAT     = 5'd13;
	localparam logic [4:0] ERR_ALIGN     = 5'd14;
	localparam logic [4:0] ERR_BITS      = 5'd15;
	localparam logic [4:0] ERR_FRAME     = 5'd16;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
	localparam logic [15:0] FMT_PCM   = 16'h0001;
	localparam logic [15:0] FMT_FLOAT = 16'h0003;

	// Bytes of the PCM subformat GUID; the float GUID differs only in byte zero.
	function automatic logic [7:0] guid_byte(input logic [3:0] k);
		logic [7:0] g;
		case (k)
			4'd0:    g = 8'h01;
			4'd6:    g = 8'h10;
			4'd8:    g = 8'h80;
			4'd11:   g = 8'hAA;
			4'd13:   g = 8'h38;
			4'd14:   g = 8'h9B;
			4'd15:   g = 8'h71;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

### rtl/wav_header_parser_unit.sv
// WAV header parser. The input channel carries one file byte per transfer
// with a file_start flag on byte zero and the file length on every byte.
// The output channel carries one result per file: the first error found,
// or the decoded format, channel count, rate, sample width, frame count and
// the offset and size of the audio data.
// Bytes are taken at one per cycle while the header and chunks are walked.
// An error result appears in the cycle after the byte that caused it. When the
// chunk walk ends, the input stalls while the format checks run and, if they
// pass, while the shift-subtract frame division runs and the result register
// is loaded. The input also stalls while a result waits.
// A new file_start byte drops any file in progress without a result.
// Bytes outside a file, or after its result, are taken and ignored.
// Reset returns the block to idle with no file open and no result pending.
// If the receiver stalls, the result is held stable and the input stays
// stalled until the result transfer completes.
`default_nettype none
module wav_header_parser_unit import wavhp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	// Commands from the controller and status back from the datapath.
	cmd_t    cmd;
	status_t st;

	wavhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.st        (st),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// The datapath holds all per-file fields and the result register.
	wavhp_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.st      (st),
		.res     (out_data)
	);

endmodule
`default_nettype wire

### rtl/wavhp_div.sv
`default_nettype none
module wavhp_div import wavhp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [17:0] den,
	output logic             done,
	output logic [31:0]      quo,
	output logic             rem_nz
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [17:0] rem_q;
	logic [31:0] quo_q;
	logic [17:0] den_q;
	logic        done_q;
	logic [18:0] sh;
	logic [18:0] diff;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, restoring form.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= diff[17:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= sh[17:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign quo    = quo_q;
	assign rem_nz = (rem_q != '0);

endmodule
`default_nettype wire

### rtl/wavhp_dp.sv
`default_nettype none
module wavhp_dp import wavhp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire in_t  in_data,
	input  wire cmd_t cmd,
	output status_t   st,
	output out_t      res
);

	logic [32:0] pos_q, riff_end_q, cds_q;
	logic [31:0] len_q, tag_q, rate_q, dstart_q, dlen_q;
	logic [15:0] ft_q, ch_q, ba_q, sb_q, vb_q, ext_q;
	logic [1:0]  gfl_q;
	logic        seen_q;
	logic [2:0]  hdr_q;
	out_t        res_q;

	logic [32:0] pos_n, riff_end_n, cds_n;
	logic [31:0] len_n, tag_n, rate_n, dstart_n, dlen_n;
	logic [15:0] ft_n, ch_n, ba_n, sb_n, vb_n, ext_n;
	logic [1:0]  gfl_n;
	logic        seen_n;
	logic [2:0]  hdr_n;

	logic        fail, concl, sc_req;
	logic [4:0]  code;
	logic [33:0] sc_c;
	phase_t      ph, nph;
	logic [32:0] p, room, padded, i;
	logic [7:0]  b, g, wf;
	logic [3:0]  k;

	logic        chk_fail;
	logic [4:0]  chk_code;
	logic [28:0] prod;
	logic        div_done, rem_nz;
	logic [31:0] quo;

	always_comb begin
		pos_n = pos_q; riff_end_n = riff_end_q; cds_n = cds_q;
		len_n = len_q; tag_n = tag_q; rate_n = rate_q; dstart_n = dstart_q; dlen_n = dlen_q;
		ft_n = ft_q; ch_n = ch_q; ba_n = ba_q; sb_n = sb_q; vb_n = vb_q; ext_n = ext_q;
		gfl_n = gfl_q; seen_n = seen_q; hdr_n = hdr_q;
		fail = 1'b0; concl = 1'b0; sc_req = 1'b0; code = ERR_OK; sc_c = '0;
		b = in_data.data_byte;
		ph = cmd.ph;
		i = '0; k = '0; g = '0; wf = '0;
		if (in_data.file_start) begin
			pos_n = '0; riff_end_n = '0; cds_n = '0;
			len_n = '0; tag_n = '0; rate_n = '0; dstart_n = '0; dlen_n = '0;
			ft_n = '0; ch_n = '0; ba_n = '0; sb_n = '0; vb_n = '0; ext_n = '0;
			gfl_n = 2'b11; seen_n = 1'b0; hdr_n = '0;
			if (in_data.file_length < 32'd12) begin
				fail = 1'b1;
				code = ERR_SIZE;
				ph   = PH_IDLE;
			end else begin
				ph = PH_HEAD;
			end
		end
		nph = ph;
		p = pos_n;
		if (ph == PH_HEAD || ph == PH_CHDR || ph == PH_BODY) begin
			pos_n = p + 33'd1;
		end
		room   = riff_end_n - cds_n;
		padded = {1'b0, len_n} + {32'd0, len_n[0]};
		case (ph)
			PH_HEAD: begin
				if (p < 33'd4 || (p >= 33'd8 && p < 33'd12)) begin
					tag_n = {tag_n[23:0], b};
				end else if (p < 33'd8) begin
					len_n = {b, len_n[31:8]};
				end
				if (p == 33'd3 && tag_n != TAG_RIFF) begin
					fail = 1'b1; code = ERR_NO_RIFF;
				end
				if (p == 33'd7) begin
					riff_end_n = 33'd8 + {1'b0, len_n};
					if (riff_end_n > {1'b0, in_data.file_length}) begin
						fail = 1'b1; code = ERR_SIZE;
					end
				end
				if (p == 33'd11) begin
					if (tag_n != TAG_WAVE) begin
						fail = 1'b1; code = ERR_NOT_WAVE;
					end else begin
						sc_req = 1'b1; sc_c = 34'd12;
					end
				end
			end
			PH_CHDR: begin
				if (hdr_n < 3'd4) begin
					tag_n = {tag_n[23:0], b};
				end else begin
					len_n = {b, len_n[31:8]};
				end
				if (hdr_n == 3'd7) begin
					padded = {1'b0, len_n} + {32'd0, len_n[0]};
					if ({1'b0, len_n} > room) begin
						fail = 1'b1; code = ERR_CHUNK;
					end else if (tag_n == TAG_FMT) begin
						if (len_n < 32'd16) begin
							fail = 1'b1; code = ERR_FMT_SMALL;
						end else begin
							gfl_n = 2'b11;
						end
					end else begin
						if (tag_n == TAG_DATA) begin
							seen_n   = 1'b1;
							dstart_n = cds_n[31:0];
							dlen_n   = len_n;
						end
						if (padded > room) begin
							fail = 1'b1; code = ERR_CHUNK;
						end
					end
					if (!fail) begin
						if (padded == '0) begin
							sc_req = 1'b1; sc_c = {1'b0, cds_n};
						end else begin
							nph = PH_BODY;
						end
					end
				end
				hdr_n = hdr_n + 3'd1;
			end
			PH_BODY: begin
				if (tag_n == TAG_FMT && p >= cds_n) begin
					i = p - cds_n;
					if (i < 33'd16) begin
						case (i[3:0])
							4'd0:    ft_n[7:0]    = b;
							4'd1:    ft_n[15:8]   = b;
							4'd2:    ch_n[7:0]    = b;
							4'd3:    ch_n[15:8]   = b;
							4'd4:    rate_n[7:0]  = b;
							4'd5:    rate_n[15:8] = b;
							4'd6:    rate_n[23:16] = b;
							4'd7:    rate_n[31:24] = b;
							4'd12:   ba_n[7:0]    = b;
							4'd13:   ba_n[15:8]   = b;
							4'd14:   sb_n[7:0]    = b;
							4'd15:   sb_n[15:8]   = b;
							default: ;
						endcase
						if (i == 33'd15) begin
							if (ft_n != FMT_EXTENSIBLE) begin
								vb_n = sb_n;
								if (padded > room) begin
									fail = 1'b1; code = ERR_CHUNK;
								end
							end else if (len_n < 32'd40) begin
								fail = 1'b1; code = ERR_EXT_SMALL;
							end
						end
					end else if (ft_n == FMT_EXTENSIBLE && i < 33'd40) begin
						if (i == 33'd16) begin
							ext_n[7:0] = b;
						end else if (i == 33'd17) begin
							ext_n[15:8] = b;
							if (ext_n < 16'd22 ||
							    (33'd18 + {17'd0, ext_n}) > {1'b0, len_n}) begin
								fail = 1'b1; code = ERR_EXT_SIZE;
							end
						end else if (i == 33'd18) begin
							vb_n[7:0] = b;
						end else if (i == 33'd19) begin
							vb_n[15:8] = b;
						end else if (i >= 33'd24) begin
							k  = i[3:0] - 4'd8;
							g  = guid_byte(k);
							wf = (k == 4'd0) ? FMT_FLOAT[7:0] : g;
							if (b != g) begin
								gfl_n = gfl_n & 2'b10;
							end
							if (b != wf) begin
								gfl_n = gfl_n & 2'b01;
							end
							if (i == 33'd39) begin
								if (gfl_n[0]) begin
									ft_n = FMT_PCM;
								end else if (gfl_n[1]) begin
									ft_n = FMT_FLOAT;
								end else begin
									fail = 1'b1; code = ERR_SUBFMT;
								end
								if (!fail && padded > room) begin
									fail = 1'b1; code = ERR_CHUNK;
								end
							end
						end
					end
				end
				if (!fail && ({1'b0, p} + 34'd1) == ({1'b0, cds_n} + {1'b0, padded})) begin
					sc_req = 1'b1; sc_c = {1'b0, p} + 34'd1;
				end
			end
			default: ;
		endcase
		// Open the next chunk header; verdict past the RIFF end, ERR_CHDR past file end.
		if (sc_req && !fail) begin
			if (({1'b0, sc_c} + 35'd8) > {2'b00, riff_end_n}) begin
				concl = 1'b1;
			end else if (sc_c > {2'b00, in_data.file_length} ||
			             ({2'b00, in_data.file_length} - sc_c) < 34'd8) begin
				fail = 1'b1; code = ERR_CHDR;
			end else begin
				nph   = PH_CHDR;
				hdr_n = '0;
				cds_n = sc_c[32:0] + 33'd8;
			end
		end
		if (fail || concl) begin
			nph = PH_IDLE;
		end
	end

	// Final checks, combinational, on the stored format fields.
	assign prod = {13'd0, ch_q} * {16'd0, sb_q[15:3]};

	always_comb begin
		chk_fail = 1'b1;
		if (!seen_q) begin
			chk_code = ERR_NO_DATA;
		end else if (ft_q != FMT_PCM && ft_q != FMT_FLOAT) begin
			chk_code = ERR_FORMAT;
		end else if (ft_q == FMT_PCM && vb_q != sb_q) begin
			chk_code = ERR_VALID;
		end else if (ft_q == FMT_FLOAT && sb_q != 16'd32) begin
			chk_code = ERR_FLOAT;
		end else if ({13'd0, ba_q} != prod) begin
			chk_code = ERR_ALIGN;
		end else if (sb_q[2:0] != 3'd0 || sb_q > 16'd32) begin
			chk_code = ERR_BITS;
		end else if (prod[17:0] == '0) begin
			chk_code = ERR_FRAME;
		end else begin
			chk_code = ERR_OK;
			chk_fail = 1'b0;
		end
	end

	wavhp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ph == PH_CONC && !chk_fail),
		.num    (dlen_q),
		.den    (prod[17:0]),
		.done   (div_done),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			pos_q <= pos_n; riff_end_q <= riff_end_n; cds_q <= cds_n;
			len_q <= len_n; tag_q <= tag_n; rate_q <= rate_n;
			dstart_q <= dstart_n; dlen_q <= dlen_n;
			ft_q <= ft_n; ch_q <= ch_n; ba_q <= ba_n; sb_q <= sb_n;
			vb_q <= vb_n; ext_q <= ext_n;
			gfl_q <= gfl_n; seen_q <= seen_n; hdr_q <= hdr_n;
		end
		if (cmd.byte_en && fail) begin
			res_q            <= '0;
			res_q.error_code <= code;
		end else if (cmd.ph == PH_CONC && chk_fail) begin
			res_q            <= '0;
			res_q.error_code <= chk_code;
		end else if (div_done) begin
			res_q <= '0;
			if (rem_nz) begin
				res_q.error_code <= ERR_FRAME;
			end else begin
				res_q.error_code   <= ERR_OK;
				res_q.is_float     <= (ft_q == FMT_FLOAT);
				res_q.channels     <= ch_q;
				res_q.rate_hz      <= rate_q;
				res_q.sample_width <= sb_q[5:0];
				res_q.frame_count  <= quo;
				res_q.audio_start  <= dstart_q;
				res_q.audio_bytes  <= dlen_q;
			end
		end
	end

	assign st.fail     = fail;
	assign st.conclude = concl;
	assign st.next_ph  = nph;
	assign st.chk_fail = chk_fail;
	assign st.div_done = div_done;
	assign res         = res_q;

endmodule
`default_nettype wire

### rtl/wavhp_ctrl.sv
`default_nettype none
module wavhp_ctrl import wavhp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    out_stall,
	input  wire status_t st,
	output logic         in_stall,
	output logic         out_valid,
	output cmd_t         cmd
);

	phase_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		accept    = 1'b0;
		case (state_q)
			PH_IDLE, PH_HEAD, PH_CHDR, PH_BODY: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					if (st.fail) begin
						state_d = PH_DONE;
					end else if (st.conclude) begin
						state_d = PH_CONC;
					end else begin
						state_d = st.next_ph;
					end
				end
			end
			PH_CONC: begin
				state_d = st.chk_fail ? PH_DONE : PH_DIV;
			end
			PH_DIV: begin
				if (st.div_done) begin
					state_d = PH_DONE;
				end
			end
			PH_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = PH_IDLE;
				end
			end
			default: state_d = PH_IDLE;
		endcase
	end

	assign cmd.ph      = state_q;
	assign cmd.byte_en = accept;

`ifndef SYNTHESIS
	a_done_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_DONE) |-> in_stall)
		else $error("input taken while a result is pending");
	a_fail_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st.fail) |=> (state_q == PH_DONE))
		else $error("error byte did not produce a result");
	a_check_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_CONC && !st.chk_fail) |=> (state_q == PH_DIV))
		else $error("passing checks did not start the division");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_DIV && st.div_done) |=> out_valid)
		else $error("division finished without a result");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_wav_header_parser_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_wav_header_parser_unit;
	import wavhp_pkg::*;

	// A byte queued for the input channel. A hold entry makes the driver wait
	// until every predicted result has been seen before it goes on.
	typedef struct {
		in_t d;
		bit  hold;
	} byte_item_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	wav_header_parser_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	byte_item_t byte_queue[$];
	out_t       verdict_queue[$];
	int         mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit         in_taken = 1'b0;
	logic [7:0] file_bytes[$];

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int TAIL_ITEMS = 200;

	// Bytes of the PCM subformat GUID. The float GUID differs in byte zero.
	logic [7:0] pcm_guid[16] = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00,
		8'h80, 8'h00, 8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71};

	// ------------------------------------------------------------------
	// Parser prediction. The state mirrors the block: a phase, a 33-bit
	// byte position, the end of the RIFF body, the current chunk and the
	// decoded format fields.
	// ------------------------------------------------------------------
	phase_t      wp_phase;
	longint unsigned wp_pos, wp_riff_end, wp_body_start;
	logic [31:0] wp_chunk_len, wp_chunk_tag, wp_rate, wp_data_start, wp_data_len;
	logic [15:0] wp_format, wp_channels, wp_align, wp_bits, wp_valid_bits, wp_ext_len;
	logic [1:0]  wp_guid_ok;
	int unsigned wp_hdr_count;
	bit          wp_data_seen, wp_done;
	out_t        wp_verdict;

	localparam longint unsigned MASK33 = 64'h1_FFFF_FFFF;

	function automatic void clear_file();
		wp_phase = PH_IDLE; wp_pos = 0; wp_riff_end = 0; wp_body_start = 0;
		wp_chunk_len = 0; wp_chunk_tag = 0; wp_rate = 0; wp_data_start = 0;
		wp_data_len = 0; wp_format = 0; wp_channels = 0; wp_align = 0; wp_bits = 0;
		wp_valid_bits = 0; wp_ext_len = 0; wp_guid_ok = 2'b11; wp_hdr_count = 0;
		wp_data_seen = 1'b0;
	endfunction

	function automatic logic [15:0] set_half(logic [15:0] f, bit hi, logic [7:0] b);
		return hi ? {b, f[7:0]} : {f[15:8], b};
	endfunction

	function automatic bit give_error(logic [4:0] code);
		wp_verdict = '0;
		wp_verdict.error_code = code;
		wp_done = 1'b1;
		wp_phase = PH_IDLE;
		return 1'b1;
	endfunction

	// Final checks of a walked file and the frame count division.
	function automatic bit close_file();
		int unsigned bits, ch, frame;
		bits = wp_bits;
		ch = wp_channels;
		if (!wp_data_seen) return give_error(ERR_NO_DATA);
		if (wp_format != FMT_PCM && wp_format != FMT_FLOAT) return give_error(ERR_FORMAT);
		if (wp_format == FMT_PCM && wp_valid_bits != wp_bits) return give_error(ERR_VALID);
		if (wp_format == FMT_FLOAT && bits != 32) return give_error(ERR_FLOAT);
		if (32'(wp_align) != 32'(ch * (bits / 8))) return give_error(ERR_ALIGN);
		if ((bits % 8) != 0 || bits > 32) return give_error(ERR_BITS);
		frame = (bits / 8) * ch;
		if (frame == 0 || wp_data_len % frame != 0) return give_error(ERR_FRAME);
		wp_verdict = '0;
		wp_verdict.error_code = ERR_OK;
		wp_verdict.is_float = (wp_format == FMT_FLOAT);
		wp_verdict.channels = 16'(ch);
		wp_verdict.rate_hz = wp_rate;
		wp_verdict.sample_width = 6'(bits);
		wp_verdict.frame_count = wp_data_len / frame;
		wp_verdict.audio_start = wp_data_start;
		wp_verdict.audio_bytes = wp_data_len;
		wp_done = 1'b1;
		wp_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic longint unsigned padded_len();
		return longint'(wp_chunk_len) + wp_chunk_len[0];
	endfunction

	function automatic bit body_overruns();
		if (padded_len() > wp_riff_end - wp_body_start) return give_error(ERR_CHUNK);
		return 1'b0;
	endfunction

	// A chunk header would begin at offset c: either the walk is over or a
	// header must fit inside the loaded file.
	function automatic bit open_chunk(longint unsigned c, longint unsigned flen);
		if (c + 8 > wp_riff_end) return close_file();
		if (c > flen || flen - c < 8) return give_error(ERR_CHDR);
		wp_phase = PH_CHDR;
		wp_hdr_count = 0;
		wp_body_start = (c + 8) & MASK33;
		return 1'b0;
	endfunction

	function automatic bit chunk_header_done(longint unsigned flen);
		if (longint'(wp_chunk_len) > wp_riff_end - wp_body_start)
			return give_error(ERR_CHUNK);
		if (wp_chunk_tag == TAG_FMT) begin
			if (wp_chunk_len < 16) return give_error(ERR_FMT_SMALL);
			wp_guid_ok = 2'b11;
		end else begin
			if (wp_chunk_tag == TAG_DATA) begin
				wp_data_seen = 1'b1;
				wp_data_start = wp_body_start[31:0];
				wp_data_len = wp_chunk_len;
			end
			if (body_overruns()) return 1'b1;
		end
		if (padded_len() == 0) return open_chunk(wp_body_start, flen);
		wp_phase = PH_BODY;
		return 1'b0;
	endfunction

	// One byte of an fmt chunk body at offset i.
	function automatic bit fmt_body_byte(longint unsigned i, logic [7:0] b);
		int unsigned k;
		logic [7:0] float_byte;
		if (i < 16) begin
			case (i)
				0, 1:       wp_format = set_half(wp_format, i[0], b);
				2, 3:       wp_channels = set_half(wp_channels, i[0], b);
				4, 5, 6, 7: wp_rate[8*(i-4) +: 8] = b;
				12, 13:     wp_align = set_half(wp_align, i[0], b);
				14, 15:     wp_bits = set_half(wp_bits, i[0], b);
				default:    ;
			endcase
			if (i == 15) begin
				if (wp_format != FMT_EXTENSIBLE) begin
					wp_valid_bits = wp_bits;
					return body_overruns();
				end
				if (wp_chunk_len < 40) return give_error(ERR_EXT_SMALL);
			end
			return 1'b0;
		end
		if (wp_format != FMT_EXTENSIBLE || i >= 40) return 1'b0;
		if (i == 16 || i == 17) begin
			wp_ext_len = set_half(wp_ext_len, i[0], b);
			if (i == 17 && (wp_ext_len < 22 || 18 + 32'(wp_ext_len) > wp_chunk_len))
				return give_error(ERR_EXT_SIZE);
		end else if (i == 18 || i == 19) begin
			wp_valid_bits = set_half(wp_valid_bits, i[0], b);
		end else if (i >= 24) begin
			k = (i - 24) & 15;
			float_byte = (k == 0) ? 8'h03 : pcm_guid[k];
			if (b != pcm_guid[k]) wp_guid_ok[0] = 1'b0;
			if (b != float_byte) wp_guid_ok[1] = 1'b0;
			if (i == 39) begin
				if (wp_guid_ok[0]) wp_format = FMT_PCM;
				else if (wp_guid_ok[1]) wp_format = FMT_FLOAT;
				else return give_error(ERR_SUBFMT);
				return body_overruns();
			end
		end
		return 1'b0;
	endfunction

	// Advances the parser by one accepted byte. Returns 1 when the byte
	// completes a file verdict, which is then left in wp_verdict.
	function automatic bit parse_byte(in_t d);
		longint unsigned p, flen;
		bit r;
		flen = d.file_length;
		r = 1'b0;
		if (d.file_start) begin
			clear_file();
			wp_done = 1'b0;
			if (flen < 12) return give_error(ERR_SIZE);
			wp_phase = PH_HEAD;
		end
		if (wp_done || wp_phase == PH_IDLE) return 1'b0;
		p = wp_pos;
		wp_pos = (p + 1) & MASK33;
		if (wp_phase == PH_HEAD) begin
			if (p < 4 || (p >= 8 && p < 12)) wp_chunk_tag = {wp_chunk_tag[23:0], d.data_byte};
			else if (p < 8) wp_chunk_len = {d.data_byte, wp_chunk_len[31:8]};
			if (p == 3 && wp_chunk_tag != TAG_RIFF) return give_error(ERR_NO_RIFF);
			if (p == 7) begin
				wp_riff_end = 8 + longint'(wp_chunk_len);
				if (wp_riff_end > flen) return give_error(ERR_SIZE);
			end
			if (p == 11) begin
				if (wp_chunk_tag != TAG_WAVE) return give_error(ERR_NOT_WAVE);
				r = open_chunk(12, flen);
			end
			return r;
		end
		if (wp_phase == PH_CHDR) begin
			if (wp_hdr_count < 4) wp_chunk_tag = {wp_chunk_tag[23:0], d.data_byte};
			else wp_chunk_len = {d.data_byte, wp_chunk_len[31:8]};
			wp_hdr_count++;
			if (wp_hdr_count >= 8) r = chunk_header_done(flen);
			return r;
		end
		if (wp_chunk_tag == TAG_FMT && p >= wp_body_start)
			r = fmt_body_byte(p - wp_body_start, d.data_byte);
		if (!wp_done && p + 1 == wp_body_start + padded_len())
			r = open_chunk(p + 1, flen);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// File builder: WAV files with random chunks and content, then an
	// occasional corruption.
	// ------------------------------------------------------------------
	function automatic void put_tag(logic [31:0] tag);
		for (int k = 3; k >= 0; k--) file_bytes.push_back(tag[8*k +: 8]);
	endfunction

	function automatic void put_le(logic [31:0] v, int n);
		for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
	endfunction

	function automatic void put_junk_chunk();
		int unsigned n;
		n = $urandom_range(0, 5);
		put_tag($urandom);
		put_le(n, 4);
		for (int k = 0; k < n + (n & 1); k++) file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void put_fmt_chunk();
		int unsigned bits, ch, ext, flt;
		logic [31:0] rate;
		bits = 8 * $urandom_range(1, 4);
		ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 3);
		rate = ($urandom_range(0, 3) == 0) ? $urandom : 48000;
		ext = ($urandom_range(0, 2) == 0);
		flt = (bits == 32) && $urandom_range(0, 1);
		put_tag(TAG_FMT);
		put_le(ext ? 40 : 16, 4);
		put_le(ext ? FMT_EXTENSIBLE : (flt ? FMT_FLOAT : FMT_PCM), 2);
		put_le(ch, 2);
		put_le(rate, 4);
		put_le(rate * ch * bits / 8, 4);
		put_le(ch * bits / 8, 2);
		put_le(bits, 2);
		if (ext) begin
			put_le(22, 2);
			put_le(bits, 2);
			put_le($urandom, 4);
			for (int k = 0; k < 16; k++)
				file_bytes.push_back((k == 0 && flt) ? 8'h03 : pcm_guid[k]);
		end
	endfunction

	function automatic void put_data_chunk();
		int unsigned n;
		n = $urandom_range(0, 3) * $urandom_range(1, 8) + ($urandom_range(0, 5) == 0);
		put_tag(TAG_DATA);
		put_le(n, 4);
		for (int k = 0; k < n + (n & 1); k++) file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void queue_file();
		int unsigned extra, pos, total;
		logic [31:0] flen;
		byte_item_t it;
		file_bytes.delete();
		put_tag(TAG_RIFF);
		put_le(0, 4);
		put_tag(TAG_WAVE);
		if ($urandom_range(0, 3) == 0) put_junk_chunk();
		if ($urandom_range(0, 4) == 0) put_data_chunk();
		if ($urandom_range(0, 9) != 0) put_fmt_chunk();
		if ($urandom_range(0, 5) == 0) put_junk_chunk();
		if ($urandom_range(0, 9) != 0) put_data_chunk();
		if ($urandom_range(0, 7) == 0) put_fmt_chunk();
		extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		total = file_bytes.size();
		{file_bytes[7], file_bytes[6], file_bytes[5], file_bytes[4]} = 32'(total - 8);
		for (int k = 0; k < extra; k++) file_bytes.push_back(8'($urandom));
		flen = file_bytes.size();
		// Corruptions: a random byte, the file length, or a byte of the RIFF size.
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, file_bytes.size() - 1);
			file_bytes[pos] = $urandom_range(0, 1) ? 8'($urandom) : file_bytes[pos] ^ 8'h01;
		end
		if ($urandom_range(0, 11) == 0) flen = $urandom;
		else if ($urandom_range(0, 11) == 0) flen = flen - $urandom_range(1, 9);
		if ($urandom_range(0, 15) == 0) file_bytes[$urandom_range(4, 7)] = 8'($urandom);
		foreach (file_bytes[k]) begin
			it.d.data_byte = file_bytes[k];
			it.d.file_start = (k == 0);
			it.d.file_length = flen;
			it.hold = 1'b0;
			byte_queue.push_back(it);
		end
	endfunction

	function automatic void queue_byte(logic [7:0] b, bit start, logic [31:0] flen);
		byte_item_t it;
		it.d.data_byte = b;
		it.d.file_start = start;
		it.d.file_length = flen;
		it.hold = 1'b0;
		byte_queue.push_back(it);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		byte_item_t mark;
		mark.d = '0;
		mark.hold = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;

		// Directed: a byte with no file open, the short file cases, a file
		// whose RIFF size reaches past the largest length, and a wrong id.
		queue_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
		queue_byte(8'h00, 1'b1, 32'd0);
		queue_byte(8'h52, 1'b1, 32'd11);
		queue_byte(8'h55, 1'b0, 32'd11);
		queue_byte(8'h52, 1'b1, 32'hFFFF_FFFF);
		queue_byte(8'h49, 1'b0, 32'hFFFF_FFFF);
		queue_byte(8'h46, 1'b0, 32'hFFFF_FFFF);
		queue_byte(8'h46, 1'b0, 32'hFFFF_FFFF);
		repeat (4) queue_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
		queue_byte(8'h52, 1'b1, 32'd12);
		queue_byte(8'h00, 1'b0, 32'd12);
		queue_byte(8'h46, 1'b0, 32'd12);
		queue_byte(8'h46, 1'b0, 32'd12);
		// A file dropped half way by a new file_start.
		queue_byte(8'h52, 1'b1, 32'd100);
		queue_byte(8'h49, 1'b0, 32'd100);
		byte_queue.push_back(mark);

		while (byte_queue.size() < 1850) begin
			queue_file();
			if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom), 1'b0, $urandom);
			if ($urandom_range(0, 7) == 0) byte_queue.push_back(mark);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || in_valid) @(posedge clk);
		while (verdict_queue.size() != 0) @(posedge clk);
		// Idle time so that a stray extra result would still be seen.
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: changes inputs on the falling edge. A byte stays on the bus
	// until its transfer completes. Idle bursts on both sides stop once the
	// last part of the stimulus is reached.
	// ------------------------------------------------------------------
	int unsigned send_gap = 0;
	int unsigned stall_run = 0;

	always @(negedge clk) begin
		logic next_valid;
		in_t  next_data;
		bit   tail;
		byte_item_t popped;
		tail = (byte_queue.size() < TAIL_ITEMS);
		next_valid = in_valid;
		next_data = in_data;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				next_valid = 1'b0;
				if (send_gap != 0) begin
					send_gap--;
				end else if (byte_queue.size() != 0) begin
					if (byte_queue[0].hold) begin
						// Hold off until every predicted result has come out.
						if (verdict_queue.size() == 0) void'(byte_queue.pop_front());
					end else if (!tail && $urandom_range(0, 15) == 0) begin
						send_gap = $urandom_range(1, 8) - 1;
					end else begin
						popped = byte_queue.pop_front();
						next_data = popped.d;
						next_valid = 1'b1;
					end
				end
			end
			if (stall_run != 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else if (!tail && $urandom_range(0, 11) == 0) begin
				stall_run = $urandom_range(1, 8) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
		in_valid <= next_valid;
		in_data <= next_data;
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge, predict for an accepted byte and check
	// an accepted result against the oldest expected verdict.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (!arst_n) begin
			clear_file();
			wp_done = 1'b1;
			in_taken = 1'b0;
		end else begin
			in_taken = in_valid && !in_stall;
			if (in_taken && parse_byte(in_data)) verdict_queue.push_back(wp_verdict);
			if (out_valid && !out_stall) begin
				if (verdict_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: %p", out_data);
				end else begin
					want = verdict_queue.pop_front();
					if (out_data !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result mismatch at cycle %0d", cycle_count);
							$display("  expected %p", want);
							$display("  actual   %p", out_data);
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### sim.f
rtl/wavhp_pkg.sv
rtl/wavhp_div.sv
rtl/wavhp_dp.sv
rtl/wavhp_ctrl.sv
rtl/wav_header_parser_unit.sv
tb/sv/tb_wav_header_parser_unit.sv
